// File: src/swap_victim_selector_unit_defines.svh
// Assertion macros used by the swap victim selector datapath.
`ifndef SWAP_VICTIM_SELECTOR_UNIT_DEFINES_SVH
`define SWAP_VICTIM_SELECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk outside of reset.
`define SVS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk outside of reset.
`define SVS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/svs_pkg.sv
// Shared types, constants and helper functions of the swap victim selector.
package svs_pkg;

	// Size of the slot table.
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int FIELD_W   = 4;
	localparam int IDX_W     = (SLOT_W > FIELD_W) ? SLOT_W : FIELD_W;
	localparam int STAMP_W   = 16;
	localparam int STATUS_W  = 4;
	localparam int CFG_IDX_W = 2;

	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [FIELD_W-1:0]  field_slot_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [STAMP_W-1:0]  stamp_t;

	localparam slot_t LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

	// Item command codes.
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_READY_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FORK_CODE  = 2'd1;

	localparam status_t READY_CODE_RST = 4'd1;
	localparam status_t FORK_CODE_RST  = 4'd5;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_WAITER  = 2'd0,
		KIND_CURRENT = 2'd1,
		KIND_READY   = 2'd2,
		KIND_NONE    = 2'd3
	} victim_kind_t;

	// One table entry as stored in the slot RAM.
	typedef struct packed {
		logic    resident;
		status_t status;
		stamp_t  stamp;
	} svs_entry_t;

	localparam int ENTRY_W = $bits(svs_entry_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write;
		logic load;
		logic issue;
		logic finish;
	} svs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_issue;
		logic out_free;
	} svs_sts_t;

	// Map of a 4-bit start slot into the table range.
	typedef slot_t start_map_t [2**FIELD_W];

	function automatic start_map_t build_start_map();
		start_map_t m;
		for (int i = 0; i < 2**FIELD_W; i++) begin
			m[i] = SLOT_W'(i % NUM_SLOTS);
		end
		return m;
	endfunction

	localparam start_map_t START_MAP = build_start_map();

	// Reduce a table slot number to the 4-bit result field.
	function automatic field_slot_t to_field(slot_t s);
		logic [IDX_W-1:0] w;
		w = IDX_W'(s);
		return w[FIELD_W-1:0];
	endfunction

endpackage

// File: src/swap_victim_selector_unit.sv
// A write is accepted in the idle state and goes straight into the slot table. A select
// loads its parameters, scans the whole table through its read port, one slot per
// cycle, drains the last read and then loads the result register, later if the previous
// result is still waiting. One item is handled at a time: the next transaction is accepted
// only once the block is back in the idle state. Reset marks every slot unwritten through
// per-slot written flags, so it counts as not resident, and loads the status codes with 1 and 5.
module swap_victim_selector_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [svs_pkg::FIELD_W-1:0]    slot_index,
	input  logic                           resident,
	input  logic [svs_pkg::STATUS_W-1:0]   status_code,
	input  logic [svs_pkg::STAMP_W-1:0]    wait_stamp,
	input  logic [svs_pkg::STAMP_W-1:0]    wait_now,
	input  logic [svs_pkg::FIELD_W-1:0]    current_slot,
	input  logic [svs_pkg::FIELD_W-1:0]    start_slot,
	input  logic                           not_self,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [svs_pkg::FIELD_W-1:0]    victim_slot,
	output logic [1:0]                     victim_kind,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [svs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [svs_pkg::STATUS_W-1:0]   cfg_data
);

	import svs_pkg::*;

	svs_cmd_t ctl;
	svs_sts_t sts;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	svs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts),
		.ctl     (ctl)
	);

	svs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.slot_index  (slot_index),
		.resident    (resident),
		.status_code (status_code),
		.wait_stamp  (wait_stamp),
		.wait_now    (wait_now),
		.current_slot(current_slot),
		.start_slot  (start_slot),
		.not_self    (not_self),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.victim_slot (victim_slot),
		.victim_kind (victim_kind)
	);

endmodule

// File: src/svs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module svs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: src/svs_ctrl.sv
// Controller state machine that sequences table writes and victim scans.
module svs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  svs_pkg::svs_sts_t  sts,
	output svs_pkg::svs_cmd_t  ctl
);

	import svs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctl      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cmd == CMD_WRITE) begin
						ctl.write = 1'b1;
					end else begin
						ctl.load = 1'b1;
						state_d  = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				ctl.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					ctl.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/svs_datapath.sv
// Datapath: slot table, scan pointer, best-candidate registers and result register.
module svs_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  svs_pkg::svs_cmd_t                    ctl,
	output svs_pkg::svs_sts_t                    sts,
	input  logic                                 cfg_valid,
	input  logic [svs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [svs_pkg::STATUS_W-1:0]         cfg_data,
	input  logic [svs_pkg::FIELD_W-1:0]          slot_index,
	input  logic                                 resident,
	input  logic [svs_pkg::STATUS_W-1:0]         status_code,
	input  logic [svs_pkg::STAMP_W-1:0]          wait_stamp,
	input  logic [svs_pkg::STAMP_W-1:0]          wait_now,
	input  logic [svs_pkg::FIELD_W-1:0]          current_slot,
	input  logic [svs_pkg::FIELD_W-1:0]          start_slot,
	input  logic                                 not_self,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [svs_pkg::FIELD_W-1:0]          victim_slot,
	output logic [1:0]                           victim_kind
);

	import svs_pkg::*;

	`include "swap_victim_selector_unit_defines.svh"

	// Configuration registers.
	status_t ready_code_q, fork_code_q;

	// Select parameters held for the scan.
	stamp_t      now_q;
	field_slot_t cur_q;
	logic        not_self_q;

	// Scan pointer and issue count.
	slot_t pos_q, cnt_q;

	// Read pipeline.
	logic       rd_vld_s1, ent_vld_s1;
	slot_t      pos_s1;
	logic [ENTRY_W-1:0] rd_data;
	svs_entry_t rd_ent;

	// Per-slot written flags; an unwritten slot counts as not resident.
	logic entry_vld_q [NUM_SLOTS];

	// Best candidates.
	logic   have_wait_q, have_ready_q;
	stamp_t best_age_q;
	slot_t  wait_slot_q, ready_slot_q;

	// Result register.
	logic         out_valid_q;
	field_slot_t  victim_slot_q;
	victim_kind_t victim_kind_q;

	logic         wr_en;
	slot_t        wr_addr;
	svs_entry_t   wr_ent;
	logic         is_res, is_cur, is_ready, is_wait, take_wait;
	stamp_t       age;
	field_slot_t  res_slot;
	victim_kind_t res_kind;

	// Table write, dropped when the slot lies beyond the table.
	assign wr_en   = ctl.write && (32'(slot_index) < 32'(NUM_SLOTS));
	assign wr_addr = SLOT_W'(slot_index);
	assign wr_ent  = '{resident: resident, status: status_code, stamp: wait_stamp};

	svs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_SLOTS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_ent),
		.rd_en  (ctl.issue),
		.rd_addr(pos_q),
		.rd_data(rd_data)
	);

	assign rd_ent = svs_entry_t'(rd_data);

	// Written flags, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				entry_vld_q[i] <= 1'b0;
			end
		end else if (wr_en) begin
			entry_vld_q[wr_addr] <= 1'b1;
		end
	end

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_code_q <= READY_CODE_RST;
			fork_code_q  <= FORK_CODE_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_READY_CODE) begin
				ready_code_q <= cfg_data;
			end else if (cfg_index == CFG_FORK_CODE) begin
				fork_code_q <= cfg_data;
			end
		end
	end

	// Select parameters and scan pointer.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			now_q      <= wait_now;
			cur_q      <= current_slot;
			not_self_q <= not_self;
			pos_q      <= START_MAP[start_slot];
			cnt_q      <= '0;
		end else if (ctl.issue) begin
			pos_q <= (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign sts.last_issue = (cnt_q == LAST_SLOT);

	// Read pipeline tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			pos_s1     <= pos_q;
			ent_vld_s1 <= entry_vld_q[pos_q];
		end
	end

	// Classify the slot that just came out of the table.
	always_comb begin
		is_res    = ent_vld_s1 && rd_ent.resident;
		is_cur    = (IDX_W'(pos_s1) == IDX_W'(cur_q));
		is_ready  = (rd_ent.status == ready_code_q);
		is_wait   = (rd_ent.status > ready_code_q) && (rd_ent.status <= fork_code_q);
		age       = now_q - rd_ent.stamp;
		take_wait = rd_vld_s1 && is_res && !is_cur && is_wait
			&& (!have_wait_q || (age >= best_age_q));
	end

	// Best waiter and last ready slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_wait_q  <= 1'b0;
			have_ready_q <= 1'b0;
		end else if (ctl.load) begin
			have_wait_q  <= 1'b0;
			have_ready_q <= 1'b0;
		end else begin
			if (take_wait) begin
				have_wait_q <= 1'b1;
			end
			if (rd_vld_s1 && is_res && !is_cur && is_ready) begin
				have_ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_wait) begin
			best_age_q  <= age;
			wait_slot_q <= pos_s1;
		end
		if (rd_vld_s1 && is_res && !is_cur && is_ready) begin
			ready_slot_q <= pos_s1;
		end
	end

	// Final choice.
	always_comb begin
		priority if (have_wait_q) begin
			res_slot = to_field(wait_slot_q);
			res_kind = KIND_WAITER;
		end else if (!not_self_q) begin
			res_slot = cur_q;
			res_kind = KIND_CURRENT;
		end else if (have_ready_q) begin
			res_slot = to_field(ready_slot_q);
			res_kind = KIND_READY;
		end else begin
			res_slot = '0;
			res_kind = KIND_NONE;
		end
	end

	// Result register with its handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			victim_slot_q <= res_slot;
			victim_kind_q <= res_kind;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign victim_slot  = victim_slot_q;
	assign victim_kind  = victim_kind_q;

	// A result is only loaded when the previous one is gone or leaving.
	`SVS_ASSERT_NOW(a_finish_free, ctl.finish, !out_valid_q || out_ready, "result overwritten")
	// A new scan never starts while a table read is still in flight.
	`SVS_ASSERT_NOW(a_load_quiet, ctl.load, !rd_vld_s1 && !ctl.issue, "scan overlaps read")
	// A result of kind none always carries slot zero.
	`SVS_ASSERT_NEXT(a_none_zero, ctl.finish && !have_wait_q && not_self_q && !have_ready_q,
		victim_slot_q == '0 && victim_kind_q == KIND_NONE, "bad empty result")

endmodule

// File: sim/swap_victim_checker.sv
// Checker for the swap victim selector: mirrors the slot table and scores every result.
`timescale 1ns / 100ps

module swap_victim_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          cmd,
	input  svs_pkg::field_slot_t          slot_index,
	input  logic                          resident,
	input  svs_pkg::status_t              status_code,
	input  svs_pkg::stamp_t               wait_stamp,
	input  svs_pkg::stamp_t               wait_now,
	input  svs_pkg::field_slot_t          current_slot,
	input  svs_pkg::field_slot_t          start_slot,
	input  logic                          not_self,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  svs_pkg::field_slot_t          victim_slot,
	input  logic [1:0]                    victim_kind,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [svs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  svs_pkg::status_t              cfg_data,
	output int                            mismatches,
	output int                            victims_owed
);

	import svs_pkg::*;

	typedef struct packed {
		field_slot_t  slot;
		victim_kind_t kind;
	} victim_t;

	// Shadow copy of the slot table and the two status code registers.
	logic    slot_live  [NUM_SLOTS];
	status_t slot_state [NUM_SLOTS];
	stamp_t  slot_age0  [NUM_SLOTS];
	status_t ready_code;
	status_t fork_code;

	victim_t victims_due [$];
	victim_t want;

	// Scans the table once from the start slot, as the block does, and returns the pick.
	function automatic victim_t pick_victim(stamp_t now, field_slot_t cur, field_slot_t start,
			logic no_self);
		victim_t v;
		int      pos;
		int      n;
		bit      got_wait;
		bit      got_ready;
		int      wait_at;
		int      ready_at;
		stamp_t  best;
		stamp_t  age;
		v.slot    = '0;
		v.kind    = KIND_NONE;
		got_wait  = 1'b0;
		got_ready = 1'b0;
		wait_at   = 0;
		ready_at  = 0;
		best      = '0;
		pos       = int'(start) % NUM_SLOTS;
		for (n = 0; n < NUM_SLOTS; n++) begin
			if (slot_live[pos] && pos != int'(cur)) begin
				if (slot_state[pos] == ready_code) begin
					got_ready = 1'b1;
					ready_at  = pos;
				end
				if (slot_state[pos] > ready_code && slot_state[pos] <= fork_code) begin
					// Age wraps at 16 bits; a tie moves the pick to the later slot.
					age = now - slot_age0[pos];
					if (!got_wait || age >= best) begin
						got_wait = 1'b1;
						best     = age;
						wait_at  = pos;
					end
				end
			end
			pos = (pos + 1) % NUM_SLOTS;
		end
		if (got_wait) begin
			v.slot = field_slot_t'(wait_at);
			v.kind = KIND_WAITER;
		end else if (!no_self) begin
			v.slot = cur;
			v.kind = KIND_CURRENT;
		end else if (got_ready) begin
			v.slot = field_slot_t'(ready_at);
			v.kind = KIND_READY;
		end
		return v;
	endfunction

	// Track configuration and input transactions, then score each output transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_live[i]  = 1'b0;
				slot_state[i] = '0;
				slot_age0[i]  = '0;
			end
			ready_code = READY_CODE_RST;
			fork_code  = FORK_CODE_RST;
			victims_due.delete();
			victims_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_READY_CODE: ready_code = cfg_data;
					CFG_FORK_CODE:  fork_code  = cfg_data;
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				if (cmd == CMD_WRITE) begin
					if (int'(slot_index) < NUM_SLOTS) begin
						slot_live[slot_index]  = resident;
						slot_state[slot_index] = status_code;
						slot_age0[slot_index]  = wait_stamp;
					end
				end else begin
					victims_due.push_back(pick_victim(wait_now, current_slot, start_slot,
						not_self));
				end
			end

			if (out_valid && out_ready) begin
				if (victims_due.size() == 0) begin
					$display("%0t: unexpected victim transaction, expected none, got slot %0d kind %0d",
						$time, victim_slot, victim_kind);
					mismatches++;
				end else begin
					want = victims_due.pop_front();
					if (victim_slot !== want.slot) begin
						$display("%0t: victim_slot mismatch, expected %0d, got %0d",
							$time, want.slot, victim_slot);
						mismatches++;
					end
					if (victim_kind !== want.kind) begin
						$display("%0t: victim_kind mismatch, expected %0d, got %0d",
							$time, want.kind, victim_kind);
						mismatches++;
					end
				end
			end

			victims_owed <= victims_due.size();
		end
	end

endmodule

// File: sim/swap_victim_selector_unit_tb.sv
// Top of the swap victim selector testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module swap_victim_selector_unit_tb;

	import svs_pkg::*;

	localparam int QUIET_LIMIT     = 4000;
	localparam int SETTLE_CYCLES   = NUM_SLOTS + 4;
	localparam int ITEMS_PER_PHASE = 150;

	// Register indexes that the block does not implement.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 cmd;
	field_slot_t          slot_index;
	logic                 resident;
	status_t              status_code;
	stamp_t               wait_stamp;
	stamp_t               wait_now;
	field_slot_t          current_slot;
	field_slot_t          start_slot;
	logic                 not_self;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	field_slot_t          victim_slot;
	logic [1:0]           victim_kind;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	status_t              cfg_data;

	int      mismatches;
	int      victims_owed;
	int      quiet_cycles   = 0;
	int      send_idle_pct  = 0;
	int      recv_stall_pct = 0;
	status_t ready_cfg;
	status_t fork_cfg;
	stamp_t  now_base;
	int      phase;

	swap_victim_selector_unit dut (.*);

	swap_victim_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side stalls at the rate of the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: give up when no transaction of any kind completes for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one item and returns at the edge that accepts it, leaving valid high.
	task automatic offer_item(logic c, field_slot_t si, logic res, status_t st, stamp_t ws,
			stamp_t wn, field_slot_t cs, field_slot_t ss, logic ns);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		slot_index   <= si;
		resident     <= res;
		status_code  <= st;
		wait_stamp   <= ws;
		wait_now     <= wn;
		current_slot <= cs;
		start_slot   <= ss;
		not_self     <= ns;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Fields a write does not use carry random values.
	task automatic write_slot(field_slot_t si, logic res, status_t st, stamp_t ws);
		offer_item(CMD_WRITE, si, res, st, ws, stamp_t'($urandom_range(65535)),
			field_slot_t'($urandom_range(15)), field_slot_t'($urandom_range(15)),
			1'($urandom_range(1)));
	endtask

	// Fields a select does not use carry random values.
	task automatic select_victim(stamp_t wn, field_slot_t cs, field_slot_t ss, logic ns);
		offer_item(CMD_SELECT, field_slot_t'($urandom_range(15)), 1'($urandom_range(1)),
			status_t'($urandom_range(15)), stamp_t'($urandom_range(65535)), wn, cs, ss, ns);
	endtask

	// Drops valid and waits until every result is in and the block has gone quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (victims_owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, status_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_READY_CODE) ready_cfg = val;
		else if (idx == CFG_FORK_CODE) fork_cfg = val;
	endtask

	// Reprograms the status codes once the block is idle.
	task automatic configure(status_t rdy, status_t frk, bit spare);
		settle();
		write_reg(CFG_READY_CODE, rdy);
		write_reg(CFG_FORK_CODE, frk);
		if (spare) begin
			write_reg(CFG_SPARE_2, status_t'($urandom_range(15)));
			write_reg(CFG_SPARE_3, status_t'($urandom_range(15)));
		end
		cfg_valid <= 1'b0;
	endtask

	// Mostly bursts of writes near the waiting code range followed by selects,
	// with some fully random items mixed in.
	task automatic run_phase(int count);
		int      done;
		int      k;
		int      burst;
		status_t st;
		stamp_t  ws;
		done = 0;
		while (done < count) begin
			if ($urandom_range(9) == 0) begin
				offer_item(1'($urandom_range(1)), field_slot_t'($urandom_range(15)),
					1'($urandom_range(1)), status_t'($urandom_range(15)),
					stamp_t'($urandom_range(65535)), stamp_t'($urandom_range(65535)),
					field_slot_t'($urandom_range(15)), field_slot_t'($urandom_range(15)),
					1'($urandom_range(1)));
				done++;
			end else begin
				// Small bases make ages wrap around zero.
				if ($urandom_range(3) == 0) now_base = stamp_t'($urandom_range(3));
				else now_base = stamp_t'($urandom_range(65535));
				burst = $urandom_range(1, 6);
				for (k = 0; k < burst; k++) begin
					if ($urandom_range(3) == 0) st = status_t'($urandom_range(15));
					else st = status_t'($urandom_range(ready_cfg,
						(fork_cfg == 4'd15) ? 15 : fork_cfg + 1));
					// Stamps close to the base give frequent equal ages.
					if ($urandom_range(3) == 0) ws = stamp_t'($urandom_range(65535));
					else ws = now_base - stamp_t'($urandom_range(8));
					write_slot(field_slot_t'($urandom_range(15)), ($urandom_range(7) != 0),
						st, ws);
					done++;
				end
				burst = $urandom_range(1, 2);
				for (k = 0; k < burst; k++) begin
					select_victim(now_base + stamp_t'($urandom_range(2)),
						field_slot_t'($urandom_range(15)), field_slot_t'($urandom_range(15)),
						1'($urandom_range(1)));
					done++;
				end
			end
		end
	endtask

	initial begin
		in_valid     <= 1'b0;
		cmd          <= CMD_WRITE;
		slot_index   <= '0;
		resident     <= 1'b0;
		status_code  <= '0;
		wait_stamp   <= '0;
		wait_now     <= '0;
		current_slot <= '0;
		start_slot   <= '0;
		not_self     <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= CFG_READY_CODE;
		cfg_data     <= '0;
		arst_n       <= 1'b0;
		ready_cfg    = READY_CODE_RST;
		fork_cfg     = FORK_CODE_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases under the reset status codes.
		select_victim(16'h0000, 4'd0, 4'd0, 1'b0);   // empty table falls back to current
		select_victim(16'hFFFF, 4'd15, 4'd15, 1'b1); // empty table, nothing to pick
		write_slot(4'd0, 1'b1, 4'd3, 16'hFFFF);
		write_slot(4'd15, 1'b1, 4'd5, 16'h0000);
		select_victim(16'h0000, 4'd9, 4'd0, 1'b1);
		select_victim(16'hFFFF, 4'd9, 4'd15, 1'b0);
		select_victim(16'h1234, 4'd0, 4'd8, 1'b1);   // oldest waiter is the current slot
		write_slot(4'd8, 1'b1, 4'd2, 16'h0000);
		select_victim(16'h0100, 4'd0, 4'd15, 1'b1);  // equal ages, later in scan wins
		select_victim(16'h0100, 4'd0, 4'd8, 1'b1);
		write_slot(4'd0, 1'b0, 4'd3, 16'hFFFF);
		write_slot(4'd8, 1'b1, 4'd1, 16'h0000);
		write_slot(4'd15, 1'b1, 4'd6, 16'h0000);
		write_slot(4'd4, 1'b1, 4'd1, 16'hAAAA);
		select_victim(16'h5555, 4'd2, 4'd0, 1'b1);   // last ready slot in scan order
		select_victim(16'h5555, 4'd2, 4'd5, 1'b1);
		select_victim(16'h5555, 4'd2, 4'd5, 1'b0);   // current slot that is not resident
		select_victim(16'h5555, 4'd15, 4'd5, 1'b0);
		write_slot(4'd4, 1'b1, 4'd0, 16'h0000);
		write_slot(4'd8, 1'b1, 4'd15, 16'hFFFF);
		select_victim(16'h0000, 4'd3, 4'd15, 1'b1);
		select_victim(16'hFFFF, 4'd8, 4'd0, 1'b1);

		// Random phases, each with its own idling pattern and status codes.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					configure(READY_CODE_RST, FORK_CODE_RST, 1'b1);
				end
				1: begin
					send_idle_pct  = 70;
					recv_stall_pct = 0;
					configure(4'd0, 4'd15, 1'b0);
				end
				2: begin
					// Empty waiting range: no slot can count as a waiter.
					send_idle_pct  = 0;
					recv_stall_pct = 70;
					configure(4'd15, 4'd0, 1'b0);
				end
				default: begin
					send_idle_pct  = 34;
					recv_stall_pct = 34;
					configure(status_t'($urandom_range(15)), status_t'($urandom_range(15)),
						1'b0);
				end
			endcase
			run_phase(ITEMS_PER_PHASE);
		end

		settle();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/svs_pkg.sv
src/svs_ram.sv
src/svs_ctrl.sv
src/svs_datapath.sv
src/swap_victim_selector_unit.sv
sim/swap_victim_checker.sv
sim/swap_victim_selector_unit_tb.sv
